### design/sbt_pkg.sv
// Shared types, codes and character classes for the S-expression byte tokenizer.
package sbt_pkg;

	localparam int POS_W   = 32;
	localparam int MAX_RES = 3;

	typedef enum logic {
		OP_DATA = 1'b0,
		OP_EOF  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		EV_CONTENT = 3'd0,
		EV_END     = 3'd1,
		EV_OPEN    = 3'd2,
		EV_CLOSE   = 3'd3,
		EV_INVALID = 3'd4,
		EV_EOF     = 3'd5
	} ev_t;

	typedef enum logic [1:0] {
		K_NUM = 2'd0,
		K_STR = 2'd1,
		K_SYM = 2'd2,
		K_CMT = 2'd3
	} kind_t;

	typedef enum logic [6:0] {
		M_START = 7'b0000001,
		M_SIGN  = 7'b0000010,
		M_NUM   = 7'b0000100,
		M_SYM   = 7'b0001000,
		M_STR   = 7'b0010000,
		M_ESC   = 7'b0100000,
		M_CMT   = 7'b1000000
	} mode_t;

	typedef struct packed {
		ev_t               event_res;
		kind_t             token_kind;
		logic [7:0]        out_byte;
		logic [POS_W-1:0]  position;
	} res_t;

	typedef struct packed {
		logic [1:0]               cnt;
		res_t [MAX_RES-1:0]       res;
	} bundle_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_LP    = 8'h28;
	localparam logic [7:0] CH_RP    = 8'h29;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_QM    = 8'h3f;
	localparam logic [7:0] CH_BS    = 8'h5c;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_ctrl_or_high(input logic [7:0] b);
		return (b < 8'h20) || (b >= 8'h80);
	endfunction

	function automatic logic is_num_char(input logic [7:0] b);
		return is_digit(b) || (b inside {"e", "E", "p", "P", "x", "X", "+", "-", ".", "_"});
	endfunction

	// Decoded value of an escape, zero when the escape is unknown.
	function automatic logic [7:0] escape_value(input logic [7:0] c);
		logic [7:0] v;
		case (c)
			CH_SQ:   v = CH_SQ;
			CH_DQ:   v = CH_DQ;
			CH_QM:   v = CH_QM;
			CH_BS:   v = CH_BS;
			"a":     v = 8'h07;
			"b":     v = 8'h08;
			"f":     v = 8'h0c;
			"n":     v = 8'h0a;
			"r":     v = 8'h0d;
			"t":     v = 8'h09;
			"v":     v = 8'h0b;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic res_t mk_res(input ev_t ev, input kind_t k, input logic [7:0] b,
			input logic [POS_W-1:0] pos);
		res_t r;
		r.event_res  = ev;
		r.token_kind = k;
		r.out_byte   = b;
		r.position   = pos;
		return r;
	endfunction

endpackage

### design/sbt_queue.sv
// Small flop queue that carries result bundles from the front to the back.
module sbt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/sbt_front.sv
// Front end: scanner state machine that turns one input beat into a bundle of results.
module sbt_front #(
	parameter int OFFSET_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              opcode,
	input  logic [7:0]        data_byte,
	input  logic              q_full,
	output logic              q_push,
	output sbt_pkg::bundle_t  q_wdata
);

	sbt_pkg::mode_t           mode_q, mode_nxt;
	logic [7:0]               sign_q, sign_nxt;
	logic [OFFSET_BITS-1:0]   offset_q, offset_nxt, offset_dec;
	logic [sbt_pkg::POS_W-1:0] pos, pos_prev;
	logic                     accept;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign offset_dec = offset_q - {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	assign pos        = sbt_pkg::POS_W'(offset_q);
	assign pos_prev   = sbt_pkg::POS_W'(offset_dec);

	always_comb begin
		sbt_pkg::mode_t m;
		logic [1:0]     n;
		logic           done;
		logic [7:0]     b;
		logic [7:0]     ev;

		m          = mode_q;
		n          = '0;
		done       = 1'b0;
		b          = data_byte;
		ev         = sbt_pkg::escape_value(data_byte);
		q_wdata    = '0;
		sign_nxt   = sign_q;
		offset_nxt = offset_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

		if (opcode == sbt_pkg::OP_EOF) begin
			// Close any open token, then report end of input.
			if (m == sbt_pkg::M_SIGN) begin
				q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_SYM,
					sign_q, pos_prev);
				n = n + 2'd1;
				q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_SYM, 8'h00, pos);
				n = n + 2'd1;
			end else if (m == sbt_pkg::M_NUM) begin
				q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_NUM, 8'h00, pos);
				n = n + 2'd1;
			end else if (m == sbt_pkg::M_SYM) begin
				q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_SYM, 8'h00, pos);
				n = n + 2'd1;
			end else if (m == sbt_pkg::M_STR || m == sbt_pkg::M_ESC) begin
				q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_STR, 8'h00, pos);
				n = n + 2'd1;
			end else if (m == sbt_pkg::M_CMT) begin
				q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_CMT, 8'h00, pos);
				n = n + 2'd1;
			end
			q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_EOF, sbt_pkg::K_NUM, 8'h00, pos);
			n = n + 2'd1;
			m          = sbt_pkg::M_START;
			sign_nxt   = 8'h00;
			offset_nxt = '0;
		end else begin
			// Held sign: decide symbol or number from this byte.
			if (m == sbt_pkg::M_SIGN) begin
				if (b == sbt_pkg::CH_SPACE || b == sbt_pkg::CH_RP) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_SYM,
						sign_q, pos_prev);
					n = n + 2'd1;
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_SYM,
						8'h00, pos);
					n = n + 2'd1;
					m = sbt_pkg::M_START;
				end else begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_NUM,
						sign_q, pos_prev);
					n = n + 2'd1;
					m = sbt_pkg::M_NUM;
				end
				sign_nxt = 8'h00;
			end

			// Token bodies; a breaking byte falls through to the start state.
			if (m == sbt_pkg::M_NUM) begin
				if (sbt_pkg::is_num_char(b)) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_NUM, b, pos);
					n = n + 2'd1;
					done = 1'b1;
				end else begin
					if (b == sbt_pkg::CH_SPACE || b == sbt_pkg::CH_RP ||
							sbt_pkg::is_ctrl_or_high(b)) begin
						q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_NUM,
							8'h00, pos);
					end else begin
						q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_INVALID, sbt_pkg::K_NUM,
							b, pos);
					end
					n = n + 2'd1;
					m = sbt_pkg::M_START;
				end
			end else if (m == sbt_pkg::M_SYM) begin
				if (b == sbt_pkg::CH_LP || b == sbt_pkg::CH_RP || b == sbt_pkg::CH_SPACE ||
						b == sbt_pkg::CH_DQ || sbt_pkg::is_ctrl_or_high(b)) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_SYM, 8'h00, pos);
					n = n + 2'd1;
					m = sbt_pkg::M_START;
				end else begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_SYM, b, pos);
					n = n + 2'd1;
					done = 1'b1;
				end
			end else if (m == sbt_pkg::M_STR) begin
				done = 1'b1;
				if (b == sbt_pkg::CH_BS) begin
					m = sbt_pkg::M_ESC;
				end else if (b == sbt_pkg::CH_DQ) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_STR, 8'h00, pos);
					n = n + 2'd1;
					m = sbt_pkg::M_START;
				end else begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_STR, b, pos);
					n = n + 2'd1;
				end
			end else if (m == sbt_pkg::M_ESC) begin
				done = 1'b1;
				if (ev != 8'h00) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_STR, ev, pos);
					n = n + 2'd1;
				end else begin
					// Unknown escape: keep the backslash and the byte.
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_STR,
						sbt_pkg::CH_BS, pos);
					n = n + 2'd1;
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_STR, b, pos);
					n = n + 2'd1;
				end
				m = sbt_pkg::M_STR;
			end else if (m == sbt_pkg::M_CMT) begin
				if (sbt_pkg::is_ctrl_or_high(b)) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_END, sbt_pkg::K_CMT, 8'h00, pos);
					n = n + 2'd1;
					m = sbt_pkg::M_START;
				end else begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_CMT, b, pos);
					n = n + 2'd1;
					done = 1'b1;
				end
			end

			if (!done && m == sbt_pkg::M_START) begin
				if (b == sbt_pkg::CH_PLUS || b == sbt_pkg::CH_MINUS) begin
					sign_nxt = b;
					m = sbt_pkg::M_SIGN;
				end else if (b == sbt_pkg::CH_DQ) begin
					m = sbt_pkg::M_STR;
				end else if (b == sbt_pkg::CH_SEMI) begin
					m = sbt_pkg::M_CMT;
				end else if (b == sbt_pkg::CH_LP) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_OPEN, sbt_pkg::K_NUM, 8'h00, pos);
					n = n + 2'd1;
				end else if (b == sbt_pkg::CH_RP) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CLOSE, sbt_pkg::K_NUM, 8'h00, pos);
					n = n + 2'd1;
				end else if (sbt_pkg::is_digit(b)) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_NUM, b, pos);
					n = n + 2'd1;
					m = sbt_pkg::M_NUM;
				end else if (b > sbt_pkg::CH_SPACE && b < sbt_pkg::CH_DEL) begin
					q_wdata.res[n] = sbt_pkg::mk_res(sbt_pkg::EV_CONTENT, sbt_pkg::K_SYM, b, pos);
					n = n + 2'd1;
					m = sbt_pkg::M_SYM;
				end
			end
		end

		q_wdata.cnt = n;
		mode_nxt    = m;
	end

	// Beats that produce nothing still advance the scanner.
	assign q_push = accept && (q_wdata.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= sbt_pkg::M_START;
			sign_q   <= 8'h00;
			offset_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_nxt;
			sign_q   <= sign_nxt;
			offset_q <= offset_nxt;
		end
	end

endmodule

### design/sbt_back.sv
// Back end: unpacks queued bundles via an output register, one result per cycle when ready.
module sbt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  sbt_pkg::bundle_t  q_rdata,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,  // out_byte [7:0], position [39:8]
	output logic [4:0]        m_tuser,  // event_res [2:0], token_kind [4:3]
	output logic              m_tlast
);

	logic           out_valid_q;
	logic           out_last_q;
	sbt_pkg::res_t  out_res_q;
	logic [1:0]     idx_q;
	logic           load;
	logic           is_last;

	assign load    = !q_empty && (!out_valid_q || m_tready);
	assign is_last = (idx_q == (q_rdata.cnt - 2'd1));
	assign q_pop   = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q  <= q_rdata.res[idx_q];
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_res_q.position, out_res_q.out_byte};
	assign m_tuser  = {out_res_q.token_kind, out_res_q.event_res};
	assign m_tlast  = out_last_q;

endmodule

### design/sexp_byte_tokenizer.sv
// Top level of the streaming S-expression byte tokenizer.
// One input beat (a text byte or end of input) is taken every cycle while the bundle queue
// has room. The scanner classifies it in that cycle and queues its zero to three results.
// Results leave one per cycle through a registered output while m_tready is high. The
// sustained rate is one input per cycle for bytes that yield at most one result, and
// one result per cycle otherwise; the output port sets that bound. The first result
// of a beat passes through the bundle queue and then the output register before it
// is valid. Position is the low 32 bits of an OFFSET_BITS-wide byte offset that wraps
// and returns to zero after end of input.
module sexp_byte_tokenizer #(
	parameter int OFFSET_BITS = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte [7:0]
	input  logic        s_tuser,   // opcode [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_byte [7:0], position [39:8]
	output logic [4:0]  m_tuser,   // event_res [2:0], token_kind [4:3]
	output logic        m_tlast
);

	localparam int BW = $bits(sbt_pkg::bundle_t);

	logic              q_push, q_full, q_pop, q_empty;
	sbt_pkg::bundle_t  q_wdata, q_rdata;
	logic [BW-1:0]     q_rdata_raw;

	sbt_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.opcode   (s_tuser),
		.data_byte(s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	sbt_queue #(
		.WIDTH(BW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata_raw),
		.empty (q_empty)
	);

	assign q_rdata = sbt_pkg::bundle_t'(q_rdata_raw);

	sbt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("bundle pushed into a full queue");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_wdata.cnt != 2'd0) && (q_wdata.cnt <= 2'd3))
		else $error("queued bundle holds no result");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("bundle popped from an empty queue");

	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (q_rdata.cnt != 2'd0)) else $error("queue head has no result");

endmodule

### tb/tb_sexp_byte_tokenizer.sv
// Self-checking stream testbench for the S-expression byte tokenizer.
`timescale 1ns / 100ps

module tb_sexp_byte_tokenizer;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 40;
	localparam int ITEM_TARGET = 220;

	typedef struct packed {
		sbt_pkg::op_t op;
		logic [7:0]   data;
	} beat_t;

	typedef struct packed {
		sbt_pkg::res_t res;
		logic          last;
	} token_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	beat_t  beat_q[$];
	token_t token_q[$];

	// predictor state
	sbt_pkg::mode_t            scan_st     = sbt_pkg::M_START;
	logic [7:0]                held_sign   = 8'h00;
	logic [sbt_pkg::POS_W-1:0] text_offset = '0;

	int unsigned n_planned   = 0;
	int unsigned n_in        = 0;
	int unsigned n_out       = 0;
	int unsigned n_eof       = 0;
	int unsigned err_count   = 0;
	int unsigned hold_left   = 0;
	int unsigned idle_cycles = 0;
	bit          hold_done   = 1'b0;

	sexp_byte_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic bit ctrl_high(input logic [7:0] b);
		return (b < 8'h20) || (b >= 8'h80);
	endfunction

	function automatic bit decimal(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic bit number_byte(input logic [7:0] b);
		return decimal(b) || b == "e" || b == "E" || b == "p" || b == "P" || b == "x" ||
			b == "X" || b == "+" || b == "-" || b == "." || b == "_";
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		case (c)
			8'h27:   return 8'h27;
			8'h22:   return 8'h22;
			8'h3f:   return 8'h3f;
			8'h5c:   return 8'h5c;
			"a":     return 8'h07;
			"b":     return 8'h08;
			"f":     return 8'h0c;
			"n":     return 8'h0a;
			"r":     return 8'h0d;
			"t":     return 8'h09;
			"v":     return 8'h0b;
			default: return 8'h00;
		endcase
	endfunction

	function automatic void add_token(input sbt_pkg::ev_t ev, input sbt_pkg::kind_t k,
			input logic [7:0] b, input logic [sbt_pkg::POS_W-1:0] pos);
		token_t t;
		t.res.event_res  = ev;
		t.res.token_kind = k;
		t.res.out_byte   = b;
		t.res.position   = pos;
		t.last           = 1'b0;
		token_q.push_back(t);
	endfunction

	// Work out the result beats of one accepted input beat.
	function automatic void tokenize_beat(input beat_t bt);
		int                        n0;
		int                        pass;
		bit                        done;
		logic [7:0]                b;
		logic [7:0]                v;
		logic [sbt_pkg::POS_W-1:0] pos;
		token_t                    t;
		n0   = token_q.size();
		b    = bt.data;
		pos  = text_offset;
		done = 1'b0;
		if (bt.op == sbt_pkg::OP_EOF) begin
			case (scan_st)
				sbt_pkg::M_SIGN: begin
					add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_SYM, held_sign, pos - 1'b1);
					add_token(sbt_pkg::EV_END, sbt_pkg::K_SYM, 8'h00, pos);
				end
				sbt_pkg::M_NUM: add_token(sbt_pkg::EV_END, sbt_pkg::K_NUM, 8'h00, pos);
				sbt_pkg::M_SYM: add_token(sbt_pkg::EV_END, sbt_pkg::K_SYM, 8'h00, pos);
				sbt_pkg::M_STR, sbt_pkg::M_ESC:
					add_token(sbt_pkg::EV_END, sbt_pkg::K_STR, 8'h00, pos);
				sbt_pkg::M_CMT: add_token(sbt_pkg::EV_END, sbt_pkg::K_CMT, 8'h00, pos);
				default:        ;
			endcase
			add_token(sbt_pkg::EV_EOF, sbt_pkg::K_NUM, 8'h00, pos);
			scan_st     = sbt_pkg::M_START;
			held_sign   = 8'h00;
			text_offset = '0;
			n_eof++;
		end else begin
			// a token-breaking byte is handled again from the start state
			for (pass = 0; pass < 4 && !done; pass++) begin
				case (scan_st)
					sbt_pkg::M_SIGN: begin
						if (b == sbt_pkg::CH_SPACE || b == sbt_pkg::CH_RP) begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_SYM, held_sign,
								pos - 1'b1);
							add_token(sbt_pkg::EV_END, sbt_pkg::K_SYM, 8'h00, pos);
							scan_st = sbt_pkg::M_START;
						end else begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_NUM, held_sign,
								pos - 1'b1);
							scan_st = sbt_pkg::M_NUM;
						end
						held_sign = 8'h00;
					end
					sbt_pkg::M_NUM: begin
						if (number_byte(b)) begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_NUM, b, pos);
							done = 1'b1;
						end else begin
							if (b == sbt_pkg::CH_SPACE || b == sbt_pkg::CH_RP || ctrl_high(b))
								add_token(sbt_pkg::EV_END, sbt_pkg::K_NUM, 8'h00, pos);
							else
								add_token(sbt_pkg::EV_INVALID, sbt_pkg::K_NUM, b, pos);
							scan_st = sbt_pkg::M_START;
						end
					end
					sbt_pkg::M_SYM: begin
						if (b == sbt_pkg::CH_LP || b == sbt_pkg::CH_RP ||
								b == sbt_pkg::CH_SPACE || b == sbt_pkg::CH_DQ ||
								ctrl_high(b)) begin
							add_token(sbt_pkg::EV_END, sbt_pkg::K_SYM, 8'h00, pos);
							scan_st = sbt_pkg::M_START;
						end else begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_SYM, b, pos);
							done = 1'b1;
						end
					end
					sbt_pkg::M_STR: begin
						if (b == sbt_pkg::CH_BS) begin
							scan_st = sbt_pkg::M_ESC;
						end else if (b == sbt_pkg::CH_DQ) begin
							add_token(sbt_pkg::EV_END, sbt_pkg::K_STR, 8'h00, pos);
							scan_st = sbt_pkg::M_START;
						end else begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_STR, b, pos);
						end
						done = 1'b1;
					end
					sbt_pkg::M_ESC: begin
						v = unescape(b);
						if (v != 8'h00) begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_STR, v, pos);
						end else begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_STR, sbt_pkg::CH_BS, pos);
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_STR, b, pos);
						end
						scan_st = sbt_pkg::M_STR;
						done    = 1'b1;
					end
					sbt_pkg::M_CMT: begin
						if (ctrl_high(b)) begin
							add_token(sbt_pkg::EV_END, sbt_pkg::K_CMT, 8'h00, pos);
							scan_st = sbt_pkg::M_START;
						end else begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_CMT, b, pos);
							done = 1'b1;
						end
					end
					default: begin
						scan_st = sbt_pkg::M_START;
						if (b == sbt_pkg::CH_PLUS || b == sbt_pkg::CH_MINUS) begin
							held_sign = b;
							scan_st   = sbt_pkg::M_SIGN;
						end else if (b == sbt_pkg::CH_DQ) begin
							scan_st = sbt_pkg::M_STR;
						end else if (b == sbt_pkg::CH_SEMI) begin
							scan_st = sbt_pkg::M_CMT;
						end else if (b == sbt_pkg::CH_LP) begin
							add_token(sbt_pkg::EV_OPEN, sbt_pkg::K_NUM, 8'h00, pos);
						end else if (b == sbt_pkg::CH_RP) begin
							add_token(sbt_pkg::EV_CLOSE, sbt_pkg::K_NUM, 8'h00, pos);
						end else if (decimal(b)) begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_NUM, b, pos);
							scan_st = sbt_pkg::M_NUM;
						end else if (b > sbt_pkg::CH_SPACE && b < sbt_pkg::CH_DEL) begin
							add_token(sbt_pkg::EV_CONTENT, sbt_pkg::K_SYM, b, pos);
							scan_st = sbt_pkg::M_SYM;
						end
						done = 1'b1;
					end
				endcase
			end
			text_offset = text_offset + 1'b1;
		end
		if (token_q.size() > n0) begin
			t      = token_q.pop_back();
			t.last = 1'b1;
			token_q.push_back(t);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	task automatic put_byte(input logic [7:0] b);
		beat_q.push_back('{op: sbt_pkg::OP_DATA, data: b});
		n_planned++;
	endtask

	task automatic put_eof();
		beat_q.push_back('{op: sbt_pkg::OP_EOF, data: 8'($urandom_range(0, 255))});
		n_planned++;
	endtask

	task automatic put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// One well-formed token with random content, now and then noise or a broken one.
	task automatic put_random_token();
		string      num_set;
		string      esc_set;
		int         r;
		int         n;
		int         i;
		logic [7:0] b;
		num_set = "0123456789eEpPxX+-._";
		esc_set = "'\"?\\abfnrtv";
		r = $urandom_range(0, 99);
		if (r < 15) begin
			put_byte(sbt_pkg::CH_LP);
		end else if (r < 30) begin
			put_byte(sbt_pkg::CH_RP);
		end else if (r < 50) begin
			if ($urandom_range(0, 1))
				put_byte($urandom_range(0, 1) ? sbt_pkg::CH_PLUS : sbt_pkg::CH_MINUS);
			put_byte(8'($urandom_range("0", "9")));
			n = $urandom_range(0, 4);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 12)
					put_byte(8'($urandom_range(8'h21, 8'h7e)));
				else if ($urandom_range(0, 3) != 0)
					put_byte(8'($urandom_range("0", "9")));
				else
					put_byte(num_set[$urandom_range(0, num_set.len() - 1)]);
			end
		end else if (r < 65) begin
			do
				b = 8'($urandom_range(8'h21, 8'h7e));
			while (decimal(b) || b == sbt_pkg::CH_LP || b == sbt_pkg::CH_RP ||
				b == sbt_pkg::CH_DQ || b == sbt_pkg::CH_SEMI || b == sbt_pkg::CH_PLUS ||
				b == sbt_pkg::CH_MINUS);
			put_byte(b);
			n = $urandom_range(0, 4);
			for (i = 0; i < n; i++)
				put_byte(8'($urandom_range(8'h21, 8'h7e)));
		end else if (r < 80) begin
			put_byte(sbt_pkg::CH_DQ);
			n = $urandom_range(0, 6);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) < 2) begin
					put_byte(sbt_pkg::CH_BS);
					if ($urandom_range(0, 2) == 0)
						put_byte(8'($urandom_range(0, 255)));
					else
						put_byte(esc_set[$urandom_range(0, esc_set.len() - 1)]);
				end else begin
					do
						b = 8'($urandom_range(0, 255));
					while (b == sbt_pkg::CH_BS || b == sbt_pkg::CH_DQ);
					put_byte(b);
				end
			end
			if ($urandom_range(0, 9) != 0)
				put_byte(sbt_pkg::CH_DQ);
		end else if (r < 88) begin
			put_byte(sbt_pkg::CH_SEMI);
			n = $urandom_range(0, 6);
			for (i = 0; i < n; i++)
				put_byte(8'($urandom_range(8'h20, 8'h7f)));
			if ($urandom_range(0, 1))
				put_byte(8'h0a);
			else if ($urandom_range(0, 1))
				put_byte(8'($urandom_range(0, 31)));
			else
				put_byte(8'($urandom_range(128, 255)));
		end else if (r < 92) begin
			put_byte($urandom_range(0, 1) ? sbt_pkg::CH_PLUS : sbt_pkg::CH_MINUS);
			put_byte($urandom_range(0, 1) ? sbt_pkg::CH_SPACE : sbt_pkg::CH_RP);
		end else if (r < 97) begin
			put_byte(8'($urandom_range(0, 255)));
		end else begin
			put_eof();
		end
		// separate tokens now and then
		r = $urandom_range(0, 9);
		if (r < 5)
			put_byte(sbt_pkg::CH_SPACE);
		else if (r < 6)
			put_byte(8'h0a);
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin : drive_proc
		beat_t nxt;
		bit    calm;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			calm = (n_in >= 120 && n_in < 170) || hold_left != 0;
			if (s_tvalid && s_tready) begin
				tokenize_beat('{op: sbt_pkg::op_t'(s_tuser), data: s_tdata});
				n_in <= n_in + 1;
			end
			// hold the beat until it is taken
			if (!s_tvalid || s_tready) begin
				if (beat_q.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
					nxt = beat_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.data;
					s_tuser  <= nxt.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_proc
		token_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_out++;
				if (token_q.size() == 0) begin
					$display({"%0t: unexpected beat, expected none, ",
						"actual ev %0d kind %0d byte %0h pos %0h last %0b"},
						$time, m_tuser[2:0], m_tuser[4:3], m_tdata[7:0], m_tdata[39:8], m_tlast);
					err_count++;
				end else begin
					want = token_q.pop_front();
					check_field("event_res", want.res.event_res, m_tuser[2:0]);
					check_field("token_kind", want.res.token_kind, m_tuser[4:3]);
					check_field("out_byte", want.res.out_byte, m_tdata[7:0]);
					check_field("position", want.res.position, m_tdata[39:8]);
					check_field("last", want.last, m_tlast);
				end
			end
			// stall the output long enough to back up the block's queue
			if (!hold_done && n_in >= 60) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= (n_in >= 120 && n_in < 170) || $urandom_range(0, 99) >= 21;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		// directed: open, sign as symbol before close, sign into number, bad byte in a
		// number, escapes known and unknown, end of input inside an escape, comment ended
		// by a high byte, end of input after a held sign, offset restart after end of input
		put_text("(-)+7g");
		put_byte(8'h00);
		put_text("\"\\n\\q\\");
		put_eof();
		put_text(";");
		put_byte(8'h7f);
		put_byte(8'hff);
		put_text("9)-");
		put_eof();
		put_text("5");
		put_byte(8'h80);
		put_text("a");
		put_eof();
		while (n_planned < ITEM_TARGET)
			put_random_token();
		put_eof();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (beat_q.size() != 0 || s_tvalid || token_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Covered %0d input beats (%0d end of input) and %0d result beats,",
			n_in, n_eof, n_out);
		$display("with random idling, a calm stretch and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
